// File: rtl/tahf_pkg.sv
// ----------------------------------------------------------------------------
// tahf_pkg
// Shared types and constants of the three-channel temperature filter.
// ----------------------------------------------------------------------------
package tahf_pkg;

  localparam int NUM_CH     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int DELTA_W    = 17;
  localparam int HYST_W     = 15;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int QDEPTH     = 4;

  localparam logic [HYST_W-1:0] HYST_RESET = 15'd16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic [HYST_W-1:0]          hyst_t;
  typedef logic [NUM_CH-1:0]          chmask_t;

  typedef enum logic {
    REG_HYST_DELTA  = 1'b0,
    REG_STERILE_THR = 1'b1
  } reg_idx_t;

endpackage

// File: rtl/tahf_sample_if.sv
// ----------------------------------------------------------------------------
// tahf_sample_if
// Sample tick channel: three readings and three read-failure flags per beat.
// ----------------------------------------------------------------------------
interface tahf_sample_if;
  import tahf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  logic    fail_0;
  logic    fail_1;
  logic    fail_2;

  modport source (
    output valid, sample_0, sample_1, sample_2, fail_0, fail_1, fail_2,
    input  ready
  );

  modport sink (
    input  valid, sample_0, sample_1, sample_2, fail_0, fail_1, fail_2,
    output ready
  );

endinterface

// File: rtl/tahf_result_if.sv
// ----------------------------------------------------------------------------
// tahf_result_if
// Result channel: filtered temperatures, deltas, sterile flag and error mask.
// ----------------------------------------------------------------------------
interface tahf_result_if;
  import tahf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t temp_0;
  sample_t temp_1;
  sample_t temp_2;
  delta_t  delta_0;
  delta_t  delta_1;
  delta_t  delta_2;
  logic    all_sterile;
  chmask_t error_mask;

  modport source (
    output valid, temp_0, temp_1, temp_2, delta_0, delta_1, delta_2,
           all_sterile, error_mask,
    input  ready
  );

  modport sink (
    input  valid, temp_0, temp_1, temp_2, delta_0, delta_1, delta_2,
           all_sterile, error_mask,
    output ready
  );

endinterface

// File: rtl/tahf_front.sv
// ----------------------------------------------------------------------------
// tahf_front
// Takes sample beats, substitutes last good samples on failed channels,
// keeps the sample window and running sums, and queues the sums once the
// window is primed.
// ----------------------------------------------------------------------------
module tahf_front #(
  parameter int WINDOW = 8,
  parameter int SUM_W  = 19,
  parameter int LVL_W  = 3
) (
  input  logic                                        clk,
  input  logic                                        rst,
  tahf_sample_if.sink                                 samples,
  input  logic [LVL_W-1:0]                            q_level,
  output logic                                        q_push,
  output logic [tahf_pkg::NUM_CH*(SUM_W+1)-1:0]       q_wdata
);
  import tahf_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int ROW_W  = NUM_CH * SAMPLE_W;

  logic [ROW_W-1:0]        win_mem [WINDOW];
  logic [POS_W-1:0]        pos;
  logic [FILL_W-1:0]       fill_count;
  chmask_t                 error_bits;
  sample_t                 last_good [NUM_CH];
  logic signed [SUM_W-1:0] window_sum [NUM_CH];

  sample_t                 raw [NUM_CH];
  chmask_t                 fail_in;
  chmask_t                 err_now;
  sample_t                 pick [NUM_CH];
  logic                    accept;
  logic                    primed;

  logic                    f_valid;
  logic                    f_full;
  logic [POS_W-1:0]        f_pos;
  sample_t                 f_s [NUM_CH];
  chmask_t                 f_err;
  logic [ROW_W-1:0]        f_old;
  logic [ROW_W-1:0]        f_row;
  sample_t                 old_s [NUM_CH];
  logic signed [SUM_W-1:0] sum_next [NUM_CH];

  // Reserve a queue slot for the beat already in flight.
  assign samples.ready = ((LVL_W+1)'(q_level) + (LVL_W+1)'(f_valid)) <
                         (LVL_W+1)'(QDEPTH);
  assign accept = samples.valid && samples.ready;
  assign primed = (fill_count == FILL_W'(WINDOW));

  always_comb begin
    raw[0]     = samples.sample_0;
    raw[1]     = samples.sample_1;
    raw[2]     = samples.sample_2;
    fail_in[0] = samples.fail_0;
    fail_in[1] = samples.fail_1;
    fail_in[2] = samples.fail_2;
    err_now    = error_bits | fail_in;
    for (int c = 0; c < NUM_CH; c++) begin
      pick[c] = err_now[c] ? last_good[c] : raw[c];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      f_row[c*SAMPLE_W +: SAMPLE_W] = f_s[c];
      old_s[c] = f_full ? sample_t'(f_old[c*SAMPLE_W +: SAMPLE_W]) : '0;
      sum_next[c] = window_sum[c] + SUM_W'(f_s[c]) - SUM_W'(old_s[c]);
      q_wdata[c*SUM_W +: SUM_W] = sum_next[c];
    end
    q_wdata[NUM_CH*SUM_W +: NUM_CH] = f_err;
  end

  assign q_push = f_valid && f_full;

  // Window row: read the oldest row on accept, overwrite it in the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_old <= win_mem[pos];
    end
    if (f_valid) begin
      win_mem[f_pos] <= f_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pos  <= pos;
      f_s    <= pick;
      f_err  <= err_now;
      f_full <= primed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      fill_count <= '0;
      error_bits <= '0;
      f_valid    <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        last_good[c]  <= '0;
        window_sum[c] <= '0;
      end
    end else begin
      f_valid <= accept;
      if (accept) begin
        error_bits <= err_now;
        for (int c = 0; c < NUM_CH; c++) begin
          if (!err_now[c]) begin
            last_good[c] <= raw[c];
          end
        end
        pos <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
        if (!primed) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (f_valid) begin
        for (int c = 0; c < NUM_CH; c++) begin
          window_sum[c] <= sum_next[c];
        end
      end
    end
  end

endmodule

// File: rtl/tahf_fifo.sv
// ----------------------------------------------------------------------------
// tahf_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module tahf_fifo #(
  parameter int W     = 60,
  parameter int DEPTH = 4,
  parameter int LVL_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     wdata,
  input  logic             pop,
  output logic [W-1:0]     rdata,
  output logic             empty,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign rdata = entries[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tahf_back.sv
// ----------------------------------------------------------------------------
// tahf_back
// Turns queued window sums into means, moves the dead bands and builds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module tahf_back #(
  parameter int WINDOW = 8,
  parameter int SUM_W  = 19
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tahf_pkg::hyst_t                       hyst_delta,
  input  tahf_pkg::sample_t                     sterile_threshold,
  input  logic                                  q_empty,
  input  logic [tahf_pkg::NUM_CH*(SUM_W+1)-1:0] q_rdata,
  output logic                                  q_pop,
  tahf_result_if.source                         results
);
  import tahf_pkg::*;

  localparam int K     = SUM_W;
  localparam int MAG_W = SAMPLE_W + 1;
  localparam int EXT_W = SAMPLE_W + 2;
  localparam logic [K-1:0] RECIP = K'((2 ** K) / WINDOW);

  function automatic sample_t sat16(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    lo = EXT_W'(sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (v > hi) begin
      sat16 = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat16 = lo[SAMPLE_W-1:0];
    end else begin
      sat16 = v[SAMPLE_W-1:0];
    end
  endfunction

  logic adv;

  // Stage A: magnitude times reciprocal
  logic signed [K-1:0] q_sum [NUM_CH];
  logic [K-1:0]        abs_sum [NUM_CH];
  logic [2*K-1:0]      prod [NUM_CH];
  logic                a_valid;
  logic [NUM_CH-1:0]   a_neg;
  logic [K-1:0]        a_abs [NUM_CH];
  logic [K-1:0]        a_q [NUM_CH];
  chmask_t             a_err;

  // Stage B: quotient correction and sign
  logic [K-1:0]            qw [NUM_CH];
  logic [K-1:0]            rem [NUM_CH];
  logic [K-1:0]            q_fin [NUM_CH];
  logic signed [MAG_W-1:0] mean_ext [NUM_CH];
  logic                    b_valid;
  sample_t                 b_mean [NUM_CH];
  chmask_t                 b_err;

  // Stage C: band state and output register
  sample_t band_low [NUM_CH];
  sample_t band_high [NUM_CH];
  sample_t last_reported [NUM_CH];
  sample_t low_next [NUM_CH];
  sample_t high_next [NUM_CH];
  delta_t  delta_next [NUM_CH];
  chmask_t over;
  logic    out_valid;
  sample_t temp [NUM_CH];
  delta_t  delta [NUM_CH];
  logic    all_sterile;
  chmask_t error_mask;
  logic signed [EXT_W-1:0] d_ext;

  assign adv   = !out_valid || results.ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      q_sum[c]   = q_rdata[c*K +: K];
      abs_sum[c] = q_sum[c][K-1] ? K'(-q_sum[c]) : K'(q_sum[c]);
      prod[c]    = (2*K)'(abs_sum[c]) * (2*K)'(RECIP);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      qw[c]    = K'(a_q[c] * K'(WINDOW));
      rem[c]   = a_abs[c] - qw[c];
      q_fin[c] = (rem[c] >= K'(WINDOW)) ? a_q[c] + 1'b1 : a_q[c];
      mean_ext[c] = a_neg[c] ? -$signed(q_fin[c][MAG_W-1:0])
                             : $signed(q_fin[c][MAG_W-1:0]);
    end
  end

  assign d_ext = EXT_W'($signed({1'b0, hyst_delta}));

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      low_next[c]  = band_low[c];
      high_next[c] = band_high[c];
      if (b_mean[c] > high_next[c]) begin
        high_next[c] = b_mean[c];
        low_next[c]  = sat16(EXT_W'(b_mean[c]) - d_ext);
      end
      if (b_mean[c] < low_next[c]) begin
        low_next[c]  = b_mean[c];
        high_next[c] = sat16(EXT_W'(b_mean[c]) + d_ext);
      end
      delta_next[c] = DELTA_W'(low_next[c]) - DELTA_W'(last_reported[c]);
      over[c]       = low_next[c] > sterile_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        a_neg[c] <= q_sum[c][K-1];
        a_abs[c] <= abs_sum[c];
        a_q[c]   <= prod[c][2*K-1:K];
        b_mean[c] <= mean_ext[c][SAMPLE_W-1:0];
      end
      a_err <= q_rdata[NUM_CH*K +: NUM_CH];
      b_err <= a_err;
    end
    if (adv && b_valid) begin
      temp        <= low_next;
      delta       <= delta_next;
      all_sterile <= &over;
      error_mask  <= b_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        band_low[c]      <= '0;
        band_high[c]     <= sample_t'({1'b0, HYST_RESET});
        last_reported[c] <= '0;
      end
    end else if (adv) begin
      a_valid   <= q_pop;
      b_valid   <= a_valid;
      out_valid <= b_valid;
      if (b_valid) begin
        band_low      <= low_next;
        band_high     <= high_next;
        last_reported <= low_next;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.temp_0      = temp[0];
  assign results.temp_1      = temp[1];
  assign results.temp_2      = temp[2];
  assign results.delta_0     = delta[0];
  assign results.delta_1     = delta[1];
  assign results.delta_2     = delta[2];
  assign results.all_sterile = all_sterile;
  assign results.error_mask  = error_mask;

endmodule

// File: rtl/temp_average_hysteresis_filter.sv
// ----------------------------------------------------------------------------
// temp_average_hysteresis_filter
// Three-channel moving average with a dead band per channel.
// ----------------------------------------------------------------------------
// Each beat on samples is one tick of three signed 16-bit readings with a
// read-failure flag each. A failure sets a sticky error bit for its channel,
// and from then on the channel repeats its own last good reading (zero if it
// never had one). Each channel averages its last WINDOW readings, truncating
// toward zero, and the mean drags a band of width hyst_delta whose low edge
// is the reported temperature; band edges saturate to 16 bits. The first
// WINDOW ticks after reset only prime the window and give no result; every
// later tick gives one result beat. The block sustains one tick per clock
// while the queue has room: the window memory is read when a beat is taken
// and the same row is rewritten the next cycle. A result passes through the
// front register, a queue entry, two back stages and the output register;
// a four-entry queue lets the sample side keep going while results are held.
// No clearing pass is needed after reset: the fill count masks window rows
// not yet written. Registers (APB, 32-bit): 0x0 hyst_delta (15 bits, reset
// 16), 0x4 sterile_threshold (signed 16 bits, reset 0). Write them only while
// the block is idle; a new hyst_delta applies the next time a band moves.
// ----------------------------------------------------------------------------
module temp_average_hysteresis_filter #(
  parameter int WINDOW = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  tahf_sample_if.sink                     samples,
  tahf_result_if.source                   results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tahf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tahf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tahf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tahf_pkg::*;

  // Running sums need log2(WINDOW) bits of headroom over a sample.
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int QW    = NUM_CH * (SUM_W + 1);
  localparam int LVL_W = $clog2(QDEPTH + 1);

  hyst_t            hyst_delta;
  sample_t          sterile_threshold;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  logic             q_push;
  logic [QW-1:0]    q_wdata;
  logic             q_pop;
  logic [QW-1:0]    q_rdata;
  logic             q_empty;
  logic [LVL_W-1:0] q_level;

  // --------------------------------------------------------------------------
  // Configuration port: zero-wait APB, registers decoded on word address
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_delta        <= HYST_RESET;
      sterile_threshold <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HYST_DELTA:  hyst_delta        <= pwdata[HYST_W-1:0];
        REG_STERILE_THR: sterile_threshold <= sample_t'(pwdata[SAMPLE_W-1:0]);
      endcase
    end
  end

  // Read back: band width zero-extended, threshold sign-extended.
  always_comb begin
    unique case (cfg_idx)
      REG_HYST_DELTA:  prdata = APB_DATA_W'(hyst_delta);
      REG_STERILE_THR: prdata = APB_DATA_W'(sterile_threshold);
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: take ticks, substitute on failure, keep window and running sums
  // --------------------------------------------------------------------------
  tahf_front #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .LVL_W  (LVL_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_level (q_level),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // --------------------------------------------------------------------------
  // Queue: hold primed sums while the result side stalls
  // --------------------------------------------------------------------------
  tahf_fifo #(
    .W     (QW),
    .DEPTH (QDEPTH),
    .LVL_W (LVL_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  // --------------------------------------------------------------------------
  // Back: divide to means, move bands, drive result beats
  // --------------------------------------------------------------------------
  tahf_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .hyst_delta        (hyst_delta),
    .sterile_threshold (sterile_threshold),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .results           (results)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // The front's slot reservation must keep the queue from overflowing.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < LVL_W'(QDEPTH)) || q_pop)
    else $error("queue push with no free entry");

  // The back pops only what is there.
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // Fill level follows pushes and pops.
  a_level_up: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |=> q_level == $past(q_level) + 1'b1)
    else $error("queue level did not advance on push");

  a_level_down: assert property (@(posedge clk) disable iff (rst)
    !q_push && q_pop |=> q_level == $past(q_level) - 1'b1)
    else $error("queue level did not drop on pop");

endmodule

// File: test/tahf_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tahf_filter_checker
// Watches the tick, result and register ports of the temperature filter,
// predicts each result beat from the accepted ticks, and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module tahf_filter_checker #(
  parameter int WINDOW = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  tahf_sample_if                          ticks,
  tahf_result_if                          readings,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tahf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tahf_pkg::APB_DATA_W-1:0] pwdata,
  output int                              mismatch_count,
  output int                              readings_pending
);
  import tahf_pkg::*;

  localparam int REPORT_MAX = 30;

  typedef struct packed {
    logic [NUM_CH-1:0][SAMPLE_W-1:0] temp;
    logic [NUM_CH-1:0][DELTA_W-1:0]  delta;
    logic                            sterile;
    chmask_t                         errors;
  } reading_t;

  sample_t  window_mem [NUM_CH][WINDOW];
  int       run_sum    [NUM_CH];
  int       band_lo    [NUM_CH];
  int       band_hi    [NUM_CH];
  int       last_temp  [NUM_CH];
  sample_t  held_sample [NUM_CH];
  int       primed_ticks;
  int       slot;
  chmask_t  err_latch;
  hyst_t    hyst;
  sample_t  sterile_thr;
  int       fault_total;
  reading_t expected_readings [$];

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic clear_filter();
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < WINDOW; k++) window_mem[c][k] = '0;
      run_sum[c]     = 0;
      band_lo[c]     = 0;
      band_hi[c]     = int'(HYST_RESET);
      last_temp[c]   = 0;
      held_sample[c] = '0;
    end
    primed_ticks = 0;
    slot         = 0;
    err_latch    = '0;
    hyst         = HYST_RESET;
    sterile_thr  = '0;
    expected_readings.delete();
  endtask

  // One tick: push each channel's sample (or its held one after a failure),
  // then move the bands once the window is primed.
  task automatic advance_filter(input logic [NUM_CH-1:0][SAMPLE_W-1:0] raw,
                                input chmask_t fails);
    sample_t  s;
    int       mean;
    int       t;
    int       diff;
    int       above;
    reading_t want;
    above = 0;
    want  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (fails[c]) err_latch[c] = 1'b1;
      if (err_latch[c]) begin
        s = held_sample[c];
      end else begin
        s = sample_t'(raw[c]);
        held_sample[c] = s;
      end
      run_sum[c] += int'(s) - int'(window_mem[c][slot]);
      window_mem[c][slot] = s;
    end
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    if (primed_ticks < WINDOW) begin
      primed_ticks++;
      return;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      mean = run_sum[c] / WINDOW;
      if (mean > band_hi[c]) begin
        band_hi[c] = mean;
        band_lo[c] = clip16(mean - int'(hyst));
      end
      if (mean < band_lo[c]) begin
        band_lo[c] = mean;
        band_hi[c] = clip16(mean + int'(hyst));
      end
      t = band_lo[c];
      if (t > int'(sterile_thr)) above++;
      diff          = t - last_temp[c];
      want.temp[c]  = t[SAMPLE_W-1:0];
      want.delta[c] = diff[DELTA_W-1:0];
      last_temp[c]  = t;
    end
    want.sterile = (above == NUM_CH);
    want.errors  = err_latch;
    expected_readings.push_back(want);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    fault_total++;
    if (fault_total <= REPORT_MAX)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic compare_reading(input reading_t want, input reading_t got);
    for (int c = 0; c < NUM_CH; c++) begin
      if (want.temp[c] !== got.temp[c])
        note_mismatch($sformatf("temp_%0d", c), $signed(want.temp[c]),
                      $signed(got.temp[c]));
      if (want.delta[c] !== got.delta[c])
        note_mismatch($sformatf("delta_%0d", c), $signed(want.delta[c]),
                      $signed(got.delta[c]));
    end
    if (want.sterile !== got.sterile)
      note_mismatch("all_sterile", want.sterile, got.sterile);
    if (want.errors !== got.errors)
      note_mismatch("error_mask", want.errors, got.errors);
  endtask

  always @(posedge clk) begin
    reading_t got;
    if (rst) begin
      clear_filter();
      fault_total = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
          REG_HYST_DELTA:  hyst        = pwdata[HYST_W-1:0];
          REG_STERILE_THR: sterile_thr = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (readings.valid && readings.ready) begin
        got.temp    = {readings.temp_2, readings.temp_1, readings.temp_0};
        got.delta   = {readings.delta_2, readings.delta_1, readings.delta_0};
        got.sterile = readings.all_sterile;
        got.errors  = readings.error_mask;
        if (expected_readings.size() == 0) begin
          fault_total++;
          if (fault_total <= REPORT_MAX)
            $display("%0t: result beat with none expected, temp_0 %0d", $time,
                     $signed(readings.temp_0));
        end else begin
          compare_reading(expected_readings.pop_front(), got);
        end
      end
      if (ticks.valid && ticks.ready)
        advance_filter({ticks.sample_2, ticks.sample_1, ticks.sample_0},
                       {ticks.fail_2, ticks.fail_1, ticks.fail_0});
    end
    mismatch_count   <= fault_total;
    readings_pending <= expected_readings.size();
  end

endmodule

// File: test/temp_average_hysteresis_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_average_hysteresis_filter_tb
// Drives sample ticks and register writes into the temperature filter and
// gives the verdict; a checker beside the block predicts and compares every
// result beat. A short directed run covers warm-up, failures and edge
// saturation, then random phases walk the readings under several settings.
// ----------------------------------------------------------------------------
module temp_average_hysteresis_filter_tb;
  import tahf_pkg::*;

  localparam int WINDOW        = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_TICKS   = 115;
  localparam int FAIL_CH1_AT   = 420;
  localparam int FAIL_CH0_AT   = 640;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_CYCLES   = 96;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 4000;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam hyst_t   HYST_MAX   = '1;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_EVERY_THIRD, RX_HEAVY} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;

  int mismatch_count;
  int readings_pending;
  int burst_left;
  int idle_cycles = 0;
  bit hold_pending;
  int level [NUM_CH];

  tahf_sample_if tick_bus ();
  tahf_result_if reading_bus ();

  temp_average_hysteresis_filter #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (tick_bus),
    .results (reading_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tahf_filter_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk              (clk),
    .rst              (rst),
    .ticks            (tick_bus),
    .readings         (reading_bus),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .readings_pending (readings_pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Abort when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst || (tick_bus.valid && tick_bus.ready) ||
        (reading_bus.valid && reading_bus.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: switch at random between stall patterns, and
  // drop ready for a long stretch once on request so the queue fills up.
  initial begin : result_backpressure
    rx_mode_t mode;
    int       mode_left;
    mode      = RX_OPEN;
    mode_left = 0;
    reading_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        reading_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        RX_OPEN:        reading_bus.ready = 1'b1;
        RX_LIGHT:       reading_bus.ready = ($urandom_range(0, 9) < 7);
        RX_EVERY_THIRD: reading_bus.ready = (mode_left % 3 == 0);
        default:        reading_bus.ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Next reading of one channel: mostly small noise around a slowly walking
  // level, so bands both hold and move; now and then a jump or an extreme.
  function automatic sample_t wander_reading(input int c);
    int pick;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 24) == 0)
      level[c] = int'(sample_t'($urandom));
    else
      level[c] = clamp16(level[c] + int'($urandom_range(0, 80)) - 40);
    if (pick == 0) return sample_t'($urandom);
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
    return sample_t'(clamp16(level[c] + int'($urandom_range(0, 48)) - 24));
  endfunction

  // One register write: setup cycle, then access until pready.
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(idx) << 2;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Fill the bits above each field with noise; the block must drop them.
  task automatic write_settings(input hyst_t hyst, input sample_t thr);
    reg_write(REG_HYST_DELTA, {17'($urandom), hyst});
    reg_write(REG_STERILE_THR, {16'($urandom), thr});
  endtask

  // Offer one tick beat; between bursts, drop valid for a random gap.
  task automatic send_tick(input logic [NUM_CH-1:0][SAMPLE_W-1:0] raw,
                           input chmask_t fails);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        tick_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    tick_bus.sample_0 = raw[0];
    tick_bus.sample_1 = raw[1];
    tick_bus.sample_2 = raw[2];
    tick_bus.fail_0   = fails[0];
    tick_bus.fail_1   = fails[1];
    tick_bus.fail_2   = fails[2];
    tick_bus.valid    = 1'b1;
    do @(posedge clk); while (!tick_bus.ready);
  endtask

  // Stop offering, wait for every expected beat, then let the pipe empty.
  task automatic drain_results();
    @(negedge clk);
    tick_bus.valid = 1'b0;
    while (readings_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                              n;
    logic [NUM_CH-1:0][SAMPLE_W-1:0] raw;
    chmask_t                         fails;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    tick_bus.valid    = 1'b0;
    tick_bus.sample_0 = '0;
    tick_bus.sample_1 = '0;
    tick_bus.sample_2 = '0;
    tick_bus.fail_0   = 1'b0;
    tick_bus.fail_1   = 1'b0;
    tick_bus.fail_2   = 1'b0;
    hold_pending      = 1'b0;
    burst_left        = 0;
    for (int c = 0; c < NUM_CH; c++) level[c] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero band width and the lowest threshold to start with.
    write_settings('0, SAMPLE_MIN);

    // Warm-up: channel 2 fails on the very first tick, so it holds zero from
    // then on; the others sit at the two rails. No result is due yet.
    send_tick({SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX}, 3'b100);
    for (int k = 1; k < WINDOW; k++)
      send_tick({sample_t'($urandom), SAMPLE_MIN, SAMPLE_MAX}, (k == 3) ? 3'b100 : 3'b000);
    // First results: rails reach the temperature outputs in one move.
    send_tick({sample_t'(12345), SAMPLE_MIN, SAMPLE_MAX}, '0);
    send_tick({sample_t'(-1), SAMPLE_MIN, SAMPLE_MAX}, '0);

    // Widest band with edges at the rails: pulling the means toward zero
    // saturates the far edge on both sides, and the new width only applies
    // as the bands move.
    drain_results();
    write_settings(HYST_MAX, SAMPLE_MAX);
    for (int k = 0; k < WINDOW; k++)
      send_tick({sample_t'($urandom), sample_t'(0), sample_t'(0)}, '0);
    send_tick({SAMPLE_MAX, sample_t'(1), sample_t'(-1)}, '0);
    send_tick({SAMPLE_MIN, sample_t'(-1), sample_t'(1)}, '0);

    // Random phases, one setting each; channel 1 and then channel 0 fail
    // late in the run so their readings stay live for most of it.
    n = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       write_settings(HYST_RESET, '0);
        1:       write_settings('0, SAMPLE_MAX);
        2:       write_settings(HYST_MAX, SAMPLE_MIN);
        default: write_settings(hyst_t'($urandom_range(0, 600)),
                                sample_t'(clamp16(level[$urandom_range(0, 1)] - 20)));
      endcase
      for (int k = 0; k < PHASE_TICKS; k++) begin
        for (int c = 0; c < NUM_CH; c++) raw[c] = wander_reading(c);
        fails[2] = ($urandom_range(0, 1) != 0);
        fails[1] = (n == FAIL_CH1_AT) || (n > FAIL_CH1_AT && $urandom_range(0, 1) != 0);
        fails[0] = (n == FAIL_CH0_AT) || (n > FAIL_CH0_AT && $urandom_range(0, 1) != 0);
        if (n == HOLD_AT) hold_pending = 1'b1;
        send_tick(raw, fails);
        n++;
      end
    end
    drain_results();

    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tahf_pkg.sv
rtl/tahf_sample_if.sv
rtl/tahf_result_if.sv
rtl/tahf_front.sv
rtl/tahf_fifo.sv
rtl/tahf_back.sv
rtl/temp_average_hysteresis_filter.sv
test/tahf_filter_checker.sv
test/temp_average_hysteresis_filter_tb.sv
